// File: hw/rtl/fir_pkg.sv
`timescale 1ns / 1ps

package fir_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = 6;
    localparam int TAPS_W   = 7;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int OUT_W    = 38;

    // Request kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Active tap count after reset
    localparam logic [TAPS_W-1:0] TAP_COUNT_RST = 7'd64;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [OUT_W-1:0]    t_acc;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic              shift;
        logic              coef_wr;
        logic [IDX_W-1:0]  coef_index;
        t_coef             coef_value;
        logic [TAPS_W-1:0] tap_count;
    } t_cell_ctl;

endpackage

// File: hw/rtl/fir_if.sv
`timescale 1ns / 1ps

// Input request channel: a sample or a coefficient write
interface fir_in_if import fir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    t_sample          sample_value;
    logic [IDX_W-1:0] coef_index;
    t_coef            coef_value;

    modport source (output valid, kind, sample_value, coef_index, coef_value, input ready);
    modport sink   (input valid, kind, sample_value, coef_index, coef_value, output ready);
endinterface

// Output request channel: one filter sum per sample
interface fir_out_if import fir_pkg::*; ();
    logic valid;
    logic ready;
    t_acc filtered_value;

    modport source (output valid, filtered_value, input ready);
    modport sink   (input valid, filtered_value, output ready);
endinterface

// File: hw/rtl/fir_filter.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                                           Accepted when
// i_in      in   kind, sample_value, coef_index, coef_value        valid & ready
// o_out     out  filtered_value                                    valid & ready
// i_cfg     in   i_cfg_we, i_cfg_data (tap_count)                  i_cfg_we
//
// One request per cycle. A taken sample passes the product register in the
// tap cells (multiply), then the registered levels of the adder tree.
// Coefficient writes give no result. The tree advances unless the output stalls,
// the cells only on a taken sample; a stalled output holds the whole pipe and
// drops ready. Reset clears the delay line, the weights and tap_count (to 64).

module fir_filter import fir_pkg::*; #(
    parameter int MAX_TAPS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fir_in_if.sink            i_in,
    fir_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [TAPS_W-1:0] i_cfg_data
);

    localparam int LVL = $clog2(MAX_TAPS);

    logic [TAPS_W-1:0] r_tap_count;
    logic [LVL:0]      r_vld;
    logic              w_en;
    logic              w_take;
    t_cell_ctl         w_ctl;
    t_sample           w_chain [MAX_TAPS+1];
    t_prod             w_prod  [MAX_TAPS];

    // Advance when the output stage is empty or being drained
    assign w_en       = !r_vld[LVL] || o_out.ready;
    assign i_in.ready = w_en;
    assign w_take     = i_in.valid && w_en;

    // Tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_data;
        end
    end

    // Broadcast control to the cells
    assign w_ctl.shift      = w_take && (i_in.kind == KIND_SAMPLE);
    assign w_ctl.coef_wr    = w_take && (i_in.kind == KIND_COEF);
    assign w_ctl.coef_index = i_in.coef_index;
    assign w_ctl.coef_value = i_in.coef_value;
    assign w_ctl.tap_count  = r_tap_count;

    // Row of tap cells; each passes its sample to the next
    assign w_chain[0] = i_in.sample_value;

    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
        fir_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_sample (w_chain[i]),
            .o_sample (w_chain[i+1]),
            .o_prod   (w_prod[i])
        );
    end

    fir_add_tree #(
        .N_IN (MAX_TAPS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_prod (w_prod),
        .o_sum  (o_out.filtered_value)
    );

    // Track which stages hold a sample result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LVL:0] << 1} | {{LVL{1'b0}}, w_ctl.shift};
        end
    end

    assign o_out.valid = r_vld[LVL];

endmodule

// File: hw/rtl/fir_cell.sv
`timescale 1ns / 1ps

module fir_cell import fir_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_sample   i_sample,
    output t_sample   o_sample,
    output t_prod     o_prod
);

    t_sample r_delay;
    t_coef   r_coef;
    t_prod   r_prod;
    t_prod   n_prod;
    logic    w_wr;
    logic    w_active;

    // Decode the coefficient write and the active tap range
    assign w_wr     = i_ctl.coef_wr && (int'(i_ctl.coef_index) == CELL_IDX);
    assign w_active = (CELL_IDX == 0) || (CELL_IDX < int'(i_ctl.tap_count));

    // Weight the sample that enters this cell; zero for inactive taps
    assign n_prod = w_active ? (t_prod'(r_coef) * t_prod'(i_sample)) : '0;

    // Hold the delay tap and the weight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_coef  <= '0;
        end else begin
            if (i_ctl.shift) begin
                r_delay <= i_sample;
            end
            if (w_wr) begin
                r_coef <= i_ctl.coef_value;
            end
        end
    end

    // Capture the product with the shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_prod <= n_prod;
        end
    end

    assign o_sample = r_delay;
    assign o_prod   = r_prod;

endmodule

// File: hw/rtl/fir_add_tree.sv
`timescale 1ns / 1ps

module fir_add_tree import fir_pkg::*; #(
    parameter int N_IN = 64
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_prod i_prod [N_IN],
    output t_acc  o_sum
);

    localparam int LVL   = $clog2(N_IN);
    localparam int NP    = 1 << LVL;
    localparam int LVL_N = (LVL > 0) ? LVL : 1;

    t_acc w_leaf [NP];
    t_acc r_sum  [LVL_N][NP];

    // Sign-extend the products; pad the tree with zeros
    for (genvar j = 0; j < NP; j++) begin : g_leaf
        if (j < N_IN) begin : g_used
            assign w_leaf[j] = t_acc'(i_prod[j]);
        end else begin : g_pad
            assign w_leaf[j] = '0;
        end
    end

    // Add pairs, one registered level at a time
    for (genvar l = 1; l <= LVL; l++) begin : g_lvl
        for (genvar j = 0; j < (NP >> l); j++) begin : g_node
            if (l == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_sum[0][j] <= w_leaf[2*j] + w_leaf[2*j+1];
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_sum[l-1][j] <= r_sum[l-2][2*j] + r_sum[l-2][2*j+1];
                    end
                end
            end
        end
    end

    if (LVL == 0) begin : g_single
        assign o_sum = w_leaf[0];
    end else begin : g_root
        assign o_sum = r_sum[LVL-1][0];
    end

endmodule
